FILE: rtl/pdr_pkg.sv
// Shared widths, register indexes, reset values and configuration struct
// for the potentiometer deadband to DAC rate block. No dependencies.
package pdr_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int DBAND_W   = 12;
    localparam int FREQ_W    = 20;
    localparam int POINTS_W  = 13;
    localparam int CLOCK_W   = 27;
    localparam int TMO_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 27;
    localparam int FS_W      = 16;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 33;

    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int ADC_FULL_SCALE_DEF = 4095;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK    = 3'd4;

    localparam logic [DBAND_W-1:0]  RST_DEADBAND = 12'd15;
    localparam logic [FREQ_W-1:0]   RST_FREQ_MIN = 20'd10;
    localparam logic [FREQ_W-1:0]   RST_FREQ_MAX = 20'd1000;
    localparam logic [POINTS_W-1:0] RST_POINTS   = 13'd64;
    localparam logic [CLOCK_W-1:0]  RST_CLOCK    = 27'd25000000;

    localparam logic [FREQ_W-1:0] FREQ_SAT = 20'hFFFFF;
    localparam logic [TMO_W-1:0]  TMO_SAT  = 16'hFFFF;

    typedef struct packed {
        logic [DBAND_W-1:0]  deadband;
        logic [FREQ_W-1:0]   freq_lo;
        logic [FREQ_W-1:0]   freq_hi;
        logic [POINTS_W-1:0] points_per_period;
        logic [CLOCK_W-1:0]  clock_hz;
    } t_cfg;

endpackage

FILE: rtl/pdr_fifo.sv
// Small register queue between the sample filter and the rate computation.
// Depends on nothing; the depth is to be a power of two, which the block does not enforce.
module pdr_fifo #(
    parameter int W     = 12,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_en,
    input  logic [W-1:0] i_wr_data,
    output logic         o_not_full,
    input  logic         i_rd_en,
    output logic         o_valid,
    output logic [W-1:0] o_rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_not_full = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr       = i_wr_en && o_not_full;
    assign w_rd       = i_rd_en && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/pdr_front.sv
// Deadband filter: keeps the last passed sample and forwards only samples
// that move past the deadband. Uses pdr_pkg.
module pdr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pdr_pkg::t_cfg          i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [pdr_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  logic                   i_q_not_full,
    output logic                   o_push,
    output logic [pdr_pkg::SAMPLE_W-1:0] o_push_sample
);
    import pdr_pkg::*;

    logic [SAMPLE_W-1:0] r_last;
    logic [SAMPLE_W-1:0] w_diff;
    logic                w_pass;

    assign w_diff = (i_adc_sample >= r_last) ? (i_adc_sample - r_last)
                                             : (r_last - i_adc_sample);
    assign w_pass = (w_diff > i_cfg.deadband);

    assign o_in_ready    = i_q_not_full;
    assign o_push        = i_in_valid && i_q_not_full && w_pass;
    assign o_push_sample = i_adc_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (o_push) begin
            r_last <= i_adc_sample;
        end
    end

endmodule

FILE: rtl/pdr_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
// Depends on nothing; NUM_W must be even.
module pdr_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_work;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W+1:0] r_d1;
    logic [DEN_W+1:0] r_d2;
    logic [DEN_W+1:0] r_d3;
    logic [DEN_W+1:0] w_t;
    logic [DEN_W+1:0] w_rem;
    logic [1:0]       w_digit;

    assign w_t = {r_rem, r_work[NUM_W-1 -: 2]};

    always_comb begin
        if (w_t >= r_d3) begin
            w_digit = 2'd3;
            w_rem   = w_t - r_d3;
        end else if (w_t >= r_d2) begin
            w_digit = 2'd2;
            w_rem   = w_t - r_d2;
        end else if (w_t >= r_d1) begin
            w_digit = 2'd1;
            w_rem   = w_t - r_d1;
        end else begin
            w_digit = 2'd0;
            w_rem   = w_t;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_work;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_num;
            r_rem  <= '0;
            r_d1   <= {2'b00, i_den};
            r_d2   <= {1'b0, i_den, 1'b0};
            r_d3   <= {2'b00, i_den} + {1'b0, i_den, 1'b0};
        end else if (r_busy) begin
            r_work <= {r_work[NUM_W-3:0], w_digit};
            r_rem  <= w_rem[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/pdr_back.sv
// Rate computation: maps a passed sample to a frequency and a DAC timeout
// with one shared divider, and holds the result register. Uses pdr_pkg, pdr_div.
module pdr_back #(
    parameter int ADC_FULL_SCALE = pdr_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pdr_pkg::t_cfg                i_cfg,
    input  logic                         i_q_valid,
    input  logic [pdr_pkg::SAMPLE_W-1:0] i_q_sample,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pdr_pkg::FREQ_W-1:0]   o_frequency_hz,
    output logic [pdr_pkg::TMO_W-1:0]    o_timeout_cycles
);
    import pdr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_MAPW = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_TO   = 3'd4;
    localparam logic [2:0] S_TOW  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [DIV_DEN_W-1:0] FS_DEN = DIV_DEN_W'(ADC_FULL_SCALE);

    logic [2:0]           r_state;
    logic [SAMPLE_W-1:0]  r_samp;
    logic [FREQ_W-1:0]    r_freq;
    logic [DIV_DEN_W-1:0] r_den;
    logic [TMO_W-1:0]     r_tmo;
    logic                 r_out_valid;
    logic [FREQ_W-1:0]    r_out_freq;
    logic [TMO_W-1:0]     r_out_tmo;

    logic [FREQ_W-1:0]    w_span;
    logic [DIV_NUM_W-1:0] w_prod;
    logic                 w_start;
    logic [DIV_NUM_W-1:0] w_num;
    logic [DIV_DEN_W-1:0] w_den;
    logic                 w_done;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [DIV_NUM_W-1:0] w_qmap;
    logic [DIV_NUM_W:0]   w_fsum;
    logic [FREQ_W-1:0]    w_freq;
    logic [TMO_W-1:0]     w_tmo;
    logic                 w_out_free;

    assign w_span = (i_cfg.freq_hi >= i_cfg.freq_lo)
                  ? (i_cfg.freq_hi - i_cfg.freq_lo) : '0;
    assign w_prod = DIV_NUM_W'(r_samp) * DIV_NUM_W'(w_span);

    assign w_start = (r_state == S_MAP) || (r_state == S_TO);
    assign w_num   = (r_state == S_MAP) ? w_prod : DIV_NUM_W'(i_cfg.clock_hz);
    assign w_den   = (r_state == S_MAP) ? FS_DEN : r_den;

    pdr_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_qmap = (FS_DEN == '0) ? DIV_NUM_W'(w_span) : w_quo;
    assign w_fsum = (DIV_NUM_W+1)'(i_cfg.freq_lo) + (DIV_NUM_W+1)'(w_qmap);
    assign w_freq = (w_fsum > (DIV_NUM_W+1)'(FREQ_SAT)) ? FREQ_SAT : w_fsum[FREQ_W-1:0];

    assign w_tmo = (r_den == '0) ? TMO_SAT
                 : ((w_quo[DIV_NUM_W-1:TMO_W] != '0) ? TMO_SAT : w_quo[TMO_W-1:0]);

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_q_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid      = r_out_valid;
    assign o_frequency_hz   = r_out_freq;
    assign o_timeout_cycles = r_out_tmo;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_samp <= i_q_sample;
        end
        if ((r_state == S_MAPW) && w_done) begin
            r_freq <= w_freq;
        end
        if (r_state == S_MUL) begin
            r_den <= DIV_DEN_W'(r_freq) * DIV_DEN_W'(i_cfg.points_per_period);
        end
        if ((r_state == S_TOW) && w_done) begin
            r_tmo <= w_tmo;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_freq <= r_freq;
            r_out_tmo  <= r_tmo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_q_valid) r_state <= S_MAP;
                S_MAP:  r_state <= S_MAPW;
                S_MAPW: if (w_done) r_state <= S_MUL;
                S_MUL:  r_state <= S_TO;
                S_TO:   r_state <= S_TOW;
                S_TOW:  if (w_done) r_state <= S_OUT;
                S_OUT:  if (w_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/pot_deadband_to_dac_rate_unit.sv
// Top level of the potentiometer deadband to DAC rate block: configuration
// registers, deadband filter, sample queue and rate computation.
// Uses pdr_pkg, pdr_front, pdr_fifo, pdr_back.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one ADC sample per item.
//   A sample within the deadband of the last passed sample is taken and
//   dropped without a result. A passed sample yields one result item on
//   the output channel (o_out_valid / i_out_ready): the mapped frequency
//   and the DAC timeout in timer cycles, saturated to 65535.
//   The filter takes a sample every cycle while the queue has room. The
//   rate computation takes one passed sample at a time: the shared radix-4
//   divider gives the frequency, a multiply by points per period forms the
//   divisor, the divider gives the timeout, and the result is registered.
//   A finished result waits in the output register while the next sample
//   is computed; a stalled receiver holds the computation once the next
//   result is ready, then the queue fills and o_in_ready drops.
//   Reset (synchronous, active low) loads the register defaults, clears the
//   stored sample and empties the queue and output. Configuration writes
//   (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; unknown indexes
//   are ignored.
module pot_deadband_to_dac_rate_unit #(
    parameter int ADC_FULL_SCALE = pdr_pkg::ADC_FULL_SCALE_DEF,
    parameter int QUEUE_DEPTH    = pdr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pdr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [pdr_pkg::SAMPLE_W-1:0]     i_adc_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pdr_pkg::FREQ_W-1:0]       o_frequency_hz,
    output logic [pdr_pkg::TMO_W-1:0]        o_timeout_cycles
);
    import pdr_pkg::*;

    t_cfg                r_cfg;
    logic                w_q_not_full;
    logic                w_push;
    logic [SAMPLE_W-1:0] w_push_sample;
    logic                w_q_valid;
    logic [SAMPLE_W-1:0] w_q_sample;
    logic                w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband          <= RST_DEADBAND;
            r_cfg.freq_lo           <= RST_FREQ_MIN;
            r_cfg.freq_hi           <= RST_FREQ_MAX;
            r_cfg.points_per_period <= RST_POINTS;
            r_cfg.clock_hz          <= RST_CLOCK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEADBAND: r_cfg.deadband          <= i_cfg_data[DBAND_W-1:0];
                REG_FREQ_MIN: r_cfg.freq_lo           <= i_cfg_data[FREQ_W-1:0];
                REG_FREQ_MAX: r_cfg.freq_hi           <= i_cfg_data[FREQ_W-1:0];
                REG_POINTS:   r_cfg.points_per_period <= i_cfg_data[POINTS_W-1:0];
                REG_CLOCK:    r_cfg.clock_hz          <= i_cfg_data[CLOCK_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    pdr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_adc_sample  (i_adc_sample),
        .i_q_not_full  (w_q_not_full),
        .o_push        (w_push),
        .o_push_sample (w_push_sample)
    );

    pdr_fifo #(
        .W     (SAMPLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_push),
        .i_wr_data  (w_push_sample),
        .o_not_full (w_q_not_full),
        .i_rd_en    (w_q_pop),
        .o_valid    (w_q_valid),
        .o_rd_data  (w_q_sample)
    );

    pdr_back #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (w_q_valid),
        .i_q_sample       (w_q_sample),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frequency_hz   (o_frequency_hz),
        .o_timeout_cycles (o_timeout_cycles)
    );

endmodule

FILE: tb/sv/pot_rate_checker.sv
// Checker for pot_deadband_to_dac_rate_unit: watches the configuration port
// and both item channels, predicts frequency and timeout per passed sample.
// Uses pdr_pkg for widths, register indexes and reset values.
module pot_rate_checker #(
    parameter int FULL_SCALE = pdr_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [pdr_pkg::SAMPLE_W-1:0]   i_adc_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [pdr_pkg::FREQ_W-1:0]     i_frequency_hz,
    input  logic [pdr_pkg::TMO_W-1:0]      i_timeout_cycles,
    output int                             o_errors,
    output int                             o_pending
);
    import pdr_pkg::*;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [TMO_W-1:0]  tmo;
    } t_rate;

    t_cfg                cfg;
    logic [SAMPLE_W-1:0] last_passed;
    logic [SAMPLE_W-1:0] sample_diff;
    t_rate               pending_rates[$];
    t_rate               want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_rate rate_for(input logic [SAMPLE_W-1:0] s);
        logic [63:0] span;
        logic [63:0] quo;
        logic [63:0] f;
        logic [63:0] dv;
        logic [63:0] t;
        t_rate       r;
        if (cfg.freq_hi >= cfg.freq_lo)
            span = 64'(cfg.freq_hi) - 64'(cfg.freq_lo);
        else
            span = 64'd0;
        if (FULL_SCALE != 0)
            quo = (64'(s) * span) / 64'(FULL_SCALE);
        else
            quo = span;
        f = 64'(cfg.freq_lo) + quo;
        if (f > 64'(FREQ_SAT))
            f = 64'(FREQ_SAT);
        dv = f * 64'(cfg.points_per_period);
        if (dv == 64'd0) begin
            t = 64'(TMO_SAT);
        end else begin
            t = 64'(cfg.clock_hz) / dv;
            if (t > 64'(TMO_SAT))
                t = 64'(TMO_SAT);
        end
        r.freq = f[FREQ_W-1:0];
        r.tmo  = t[TMO_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.deadband          = RST_DEADBAND;
            cfg.freq_lo           = RST_FREQ_MIN;
            cfg.freq_hi           = RST_FREQ_MAX;
            cfg.points_per_period = RST_POINTS;
            cfg.clock_hz          = RST_CLOCK;
            last_passed           = '0;
            pending_rates.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_rates.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected item: expected none, got freq %0d timeout %0d",
                             $time, i_frequency_hz, i_timeout_cycles);
                end else begin
                    want = pending_rates.pop_front();
                    if (want.freq !== i_frequency_hz) begin
                        o_errors++;
                        $display("%0t: frequency_hz expected %0d got %0d",
                                 $time, want.freq, i_frequency_hz);
                    end
                    if (want.tmo !== i_timeout_cycles) begin
                        o_errors++;
                        $display("%0t: timeout_cycles expected %0d got %0d",
                                 $time, want.tmo, i_timeout_cycles);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEADBAND: cfg.deadband          = i_cfg_data[DBAND_W-1:0];
                    REG_FREQ_MIN: cfg.freq_lo           = i_cfg_data[FREQ_W-1:0];
                    REG_FREQ_MAX: cfg.freq_hi           = i_cfg_data[FREQ_W-1:0];
                    REG_POINTS:   cfg.points_per_period = i_cfg_data[POINTS_W-1:0];
                    REG_CLOCK:    cfg.clock_hz          = i_cfg_data[CLOCK_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_adc_sample >= last_passed)
                    sample_diff = i_adc_sample - last_passed;
                else
                    sample_diff = last_passed - i_adc_sample;
                if (sample_diff > cfg.deadband) begin
                    last_passed = i_adc_sample;
                    pending_rates.push_back(rate_for(i_adc_sample));
                end
            end
        end
        o_pending = pending_rates.size();
    end

endmodule

FILE: tb/sv/pot_deadband_to_dac_rate_unit_tb.sv
// Top of the testbench for pot_deadband_to_dac_rate_unit: clock, reset,
// register programming, sample and ready stimulus, and the verdict.
// Uses pdr_pkg, the block and pot_rate_checker.
module pot_deadband_to_dac_rate_unit_tb;
    import pdr_pkg::*;

    localparam int LIMIT         = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 1500;
    localparam int PHASE_ITEMS   = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_adc_sample;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [FREQ_W-1:0]     o_frequency_hz;
    logic [TMO_W-1:0]      o_timeout_cycles;

    int errors;
    int pending;
    int cycles;
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    pot_deadband_to_dac_rate_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_adc_sample     (i_adc_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frequency_hz   (o_frequency_hz),
        .o_timeout_cycles (o_timeout_cycles)
    );

    pot_rate_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_adc_sample     (i_adc_sample),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_frequency_hz   (o_frequency_hz),
        .i_timeout_cycles (o_timeout_cycles),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("pot_deadband_to_dac_rate_unit_tb: done, errors");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready = quiet || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    function automatic t_cfg mk_cfg(input int unsigned db, input int unsigned fmin,
                                    input int unsigned fmax, input int unsigned pts,
                                    input int unsigned clk);
        t_cfg c;
        c.deadband          = db[DBAND_W-1:0];
        c.freq_lo           = fmin[FREQ_W-1:0];
        c.freq_hi           = fmax[FREQ_W-1:0];
        c.points_per_period = pts[POINTS_W-1:0];
        c.clock_hz          = clk[CLOCK_W-1:0];
        return c;
    endfunction

    function automatic t_cfg pick_cfg(input int kind);
        t_cfg c;
        case (kind)
            0: c = mk_cfg(32'(RST_DEADBAND), 32'(RST_FREQ_MIN), 32'(RST_FREQ_MAX),
                          32'(RST_POINTS), 32'(RST_CLOCK));
            1: c = mk_cfg(0, 0, 1000000, 4096, 100000000);
            2, 7: c = mk_cfg($urandom_range(0, 200), $urandom_range(0, 100),
                             $urandom_range(0, 5000), $urandom_range(1, 64),
                             $urandom_range(1, 100000000));
            3: c = mk_cfg($urandom_range(0, 200), $urandom_range(500000, 1000000),
                          $urandom_range(0, 499999), $urandom_range(1, 4096),
                          $urandom_range(1, 100000000));
            4: c = mk_cfg($urandom_range(0, 200), $urandom_range(0, 1000),
                          $urandom_range(0, 100000), 0, $urandom_range(1, 100000000));
            5: c = mk_cfg($urandom_range(0, 200), $urandom_range(0, 1000000),
                          $urandom_range(0, 1000000), $urandom_range(1, 4096),
                          $urandom_range(1, 100000000));
            default: c = mk_cfg($urandom_range(0, 200), $urandom & 32'hFFFFF,
                                $urandom & 32'hFFFFF, $urandom & 32'h1FFF,
                                $urandom & 32'h7FFFFFF);
        endcase
        return c;
    endfunction

    task automatic program_regs(input t_cfg c);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = REG_DEADBAND;
        i_cfg_data = CFG_DATA_W'(c.deadband);
        @(negedge i_clk);
        i_cfg_idx  = REG_FREQ_MIN;
        i_cfg_data = CFG_DATA_W'(c.freq_lo);
        @(negedge i_clk);
        i_cfg_idx  = REG_FREQ_MAX;
        i_cfg_data = CFG_DATA_W'(c.freq_hi);
        @(negedge i_clk);
        i_cfg_idx  = REG_POINTS;
        i_cfg_data = CFG_DATA_W'(c.points_per_period);
        @(negedge i_clk);
        i_cfg_idx  = REG_CLOCK;
        i_cfg_data = CFG_DATA_W'(c.clock_hz);
        @(negedge i_clk);
        i_cfg_idx  = CFG_IDX_W'(REG_CLOCK + 1 + $urandom_range(0, 2));
        i_cfg_data = CFG_DATA_W'($urandom);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while (!quiet && $urandom_range(0, 99) < 22) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_adc_sample = s;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        int                  ph;
        int                  n;
        int                  v;
        logic [SAMPLE_W-1:0] prev;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_adc_sample = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_sample(12'd0);
        send_sample(12'd15);
        send_sample(12'd16);
        send_sample(12'd31);
        send_sample(12'd32);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd2048);
        drain();
        program_regs(mk_cfg(0, 0, 0, 64, 32'(RST_CLOCK)));
        send_sample(12'd1);
        send_sample(12'd0);
        send_sample(12'd4095);
        drain();
        program_regs(mk_cfg(4095, 0, 1000000, 64, 32'(RST_CLOCK)));
        send_sample(12'd0);
        send_sample(12'd4095);
        drain();
        program_regs(mk_cfg(0, 1000000, 5, 4096, 100000000));
        send_sample(12'd100);
        send_sample(12'd4000);
        drain();
        program_regs(mk_cfg(0, 0, 1048575, 0, 0));
        send_sample(12'd1);
        send_sample(12'd4095);
        drain();
        program_regs(mk_cfg(0, 1048575, 1048575, 8191, 0));
        send_sample(12'd10);
        send_sample(12'd20);
        drain();
        program_regs(mk_cfg(0, 1, 1, 1, 134217727));
        send_sample(12'd2);
        send_sample(12'd3000);

        prev = 12'd3000;
        for (ph = 0; ph < 8; ph++) begin
            drain();
            program_regs(pick_cfg(ph));
            quiet = (ph == 6);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 30)
                    hold_req = 1'b1;
                if (ph == 5 && n >= 30 && n < 60) begin
                    prev = prev ^ 12'h800;
                end else if ($urandom_range(0, 99) < 55) begin
                    prev = SAMPLE_W'($urandom);
                end else begin
                    v = int'(prev) + int'($urandom_range(0, 40)) - 20;
                    if (v < 0)
                        v = 0;
                    if (v > 4095)
                        v = 4095;
                    prev = SAMPLE_W'(v);
                end
                send_sample(prev);
            end
        end
        quiet = 1'b0;
        drain();

        if (errors == 0 && pending == 0) begin
            $display("pot_deadband_to_dac_rate_unit_tb: done, clean");
        end else begin
            if (pending != 0)
                $display("%0t: %0d expected items never arrived", $time, pending);
            $display("pot_deadband_to_dac_rate_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
